[src/mtrr_pkg.sv]
// ----------------------------------------------------------------------------
// mtrr_pkg
// Shared types, codes and helpers of the MTRR memory-type resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrr_pkg;

   localparam int FIXED_REGS = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHYS_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIRS     = 2'd1;

   // request modes
   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_WRITE  = 2'd2;

   // register map
   localparam logic [4:0] REG_DEFAULT   = 5'd0;
   localparam logic [4:0] REG_FIX_FIRST = 5'd1;
   localparam logic [4:0] REG_FIX_LAST  = 5'd11;
   localparam logic [4:0] REG_VAR_FIRST = 5'd16;

   // operation kinds after decode
   localparam logic [2:0] KIND_LOOKUP  = 3'd0;
   localparam logic [2:0] KIND_READ    = 3'd1;
   localparam logic [2:0] KIND_WRITE   = 3'd2;
   localparam logic [2:0] KIND_NOP     = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN = 3'd4;

   // register targets
   localparam logic [1:0] TGT_DEF  = 2'd0;
   localparam logic [1:0] TGT_FIX  = 2'd1;
   localparam logic [1:0] TGT_BASE = 2'd2;
   localparam logic [1:0] TGT_MASK = 2'd3;

   // response status
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_REJECT   = 2'd1;
   localparam logic [1:0] STAT_UNKNOWN  = 2'd2;
   localparam logic [1:0] STAT_CONFLICT = 2'd3;

   // memory types
   localparam logic [7:0] TYPE_UC = 8'd0;
   localparam logic [7:0] TYPE_WC = 8'd1;
   localparam logic [7:0] TYPE_WT = 8'd4;
   localparam logic [7:0] TYPE_WP = 8'd5;
   localparam logic [7:0] TYPE_WB = 8'd6;

   localparam logic [63:0] DEF_ALLOWED = 64'h0000_0000_0000_0CFF;
   localparam logic [63:0] BASE_TYPE   = 64'h0000_0000_0000_00FF;
   localparam logic [63:0] MASK_VALID  = 64'h0000_0000_0000_0800;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  target;
      logic [3:0]  fix_sel;
      logic [2:0]  fix_byte;
      logic [3:0]  pair;
      logic        addr_low;
      logic        val_ok;
      logic [63:0] value;
      logic [62:0] address;
   } op_type;

   typedef struct packed {
      logic [2:0]  mem_type;
      logic [63:0] read_data;
      logic [1:0]  status;
      logic        upd;
   } rsp_type;

   function automatic logic type_ok(input logic [7:0] t);
      return (t == TYPE_UC) || (t == TYPE_WC) || (t == TYPE_WT) ||
             (t == TYPE_WP) || (t == TYPE_WB);
   endfunction

endpackage

`default_nettype wire

[src/mtrr_if.sv]
// ----------------------------------------------------------------------------
// mtrr_if
// Channel interfaces: request, response and csr write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtrr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [4:0]  reg_index;
   logic [63:0] write_value;
   logic [62:0] phys_address;

   modport source (output valid, mode, reg_index, write_value, phys_address,
                   input ready);
   modport sink (input valid, mode, reg_index, write_value, phys_address,
                 output ready);
endinterface

interface mtrr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mem_type;
   logic [63:0] read_data;
   logic [1:0]  status;
   logic        table_update_needed;

   modport source (output valid, mem_type, read_data, status, table_update_needed,
                   input ready);
   modport sink (input valid, mem_type, read_data, status, table_update_needed,
                 output ready);
endinterface

interface mtrr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mtrr_pkg::CSR_IDX_W-1:0]   index;
   logic [mtrr_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/mtrr_ram.sv]
// ----------------------------------------------------------------------------
// mtrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [AW-1:0]         waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic [AW-1:0]         raddr,
   output      logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/mtrr_queue.sv]
// ----------------------------------------------------------------------------
// mtrr_queue
// Two-entry queue of decoded operations between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mtrr_pkg::op_type  push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic              empty,
   output      mtrr_pkg::op_type  head
);

   mtrr_pkg::op_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/mtrr_front.sv]
// ----------------------------------------------------------------------------
// mtrr_front
// Request decode: classifies each word, checks write values that need no
// stored state and locates the fixed-range byte of a lookup address.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_front (
   mtrr_req_if.sink               req,
   input  wire logic [4:0]        pairs_used,
   input  wire logic              q_full,
   output      logic              q_push,
   output      mtrr_pkg::op_type  q_data
);

   logic       fixed_ok;
   logic       def_ok;
   logic [2:0] pair_k;
   logic [3:0] lk_sel;
   logic [2:0] lk_byte;

   assign req.ready = ~q_full;
   assign q_push    = req.valid & ~q_full;
   assign pair_k    = req.reg_index[3:1];

   always_comb begin
      fixed_ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (!mtrr_pkg::type_ok(req.write_value[8*i +: 8])) begin
            fixed_ok = 1'b0;
         end
      end
      def_ok = ((req.write_value & ~mtrr_pkg::DEF_ALLOWED) == 64'd0) &&
               !(req.write_value[11] && !mtrr_pkg::type_ok(req.write_value[7:0]));
   end

   // fixed-range register and byte covering the address
   always_comb begin
      if (!req.phys_address[19]) begin
         lk_sel  = 4'd0;
         lk_byte = req.phys_address[18:16];
      end else if (req.phys_address[19:17] == 3'b100) begin
         lk_sel  = 4'd1;
         lk_byte = req.phys_address[16:14];
      end else if (req.phys_address[19:17] == 3'b101) begin
         lk_sel  = 4'd2;
         lk_byte = req.phys_address[16:14];
      end else begin
         lk_sel  = 4'd3 + {1'b0, req.phys_address[17:15]};
         lk_byte = req.phys_address[14:12];
      end
   end

   always_comb begin
      q_data          = '0;
      q_data.value    = req.write_value;
      q_data.address  = req.phys_address;
      q_data.addr_low = (req.phys_address[62:20] == 43'd0);
      q_data.pair     = {1'b0, pair_k};
      case (req.mode)
         mtrr_pkg::MODE_LOOKUP: begin
            q_data.kind     = mtrr_pkg::KIND_LOOKUP;
            q_data.fix_sel  = lk_sel;
            q_data.fix_byte = lk_byte;
         end
         mtrr_pkg::MODE_READ,
         mtrr_pkg::MODE_WRITE: begin
            q_data.kind = (req.mode == mtrr_pkg::MODE_WRITE) ?
                          mtrr_pkg::KIND_WRITE : mtrr_pkg::KIND_READ;
            if (req.reg_index == mtrr_pkg::REG_DEFAULT) begin
               q_data.target = mtrr_pkg::TGT_DEF;
               q_data.val_ok = def_ok;
            end else if (req.reg_index inside
                         {[mtrr_pkg::REG_FIX_FIRST:mtrr_pkg::REG_FIX_LAST]}) begin
               q_data.target  = mtrr_pkg::TGT_FIX;
               q_data.fix_sel = 4'(req.reg_index - mtrr_pkg::REG_FIX_FIRST);
               q_data.val_ok  = fixed_ok;
            end else if (req.reg_index >= mtrr_pkg::REG_VAR_FIRST &&
                         {2'b00, pair_k} < pairs_used) begin
               q_data.target = req.reg_index[0] ? mtrr_pkg::TGT_MASK : mtrr_pkg::TGT_BASE;
            end else begin
               q_data.kind = mtrr_pkg::KIND_UNKNOWN;
            end
         end
         default: begin
            q_data.kind = mtrr_pkg::KIND_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/mtrr_back.sv]
// ----------------------------------------------------------------------------
// mtrr_back
// Execution sequencer: holds the register set, performs reads and
// validated writes, walks the variable pairs for lookups and keeps the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_back #(
   parameter int VAR_PAIRS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire mtrr_pkg::op_type  head,
   output      logic              q_pop,
   input  wire logic [5:0]        phys_bits,
   input  wire logic [4:0]        pairs_used,
   output      mtrr_pkg::rsp_type rsp,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready
);

   localparam int PAIR_W = (VAR_PAIRS > 1) ? $clog2(VAR_PAIRS) : 1;
   localparam int PAIR_N = 1 << PAIR_W;
   localparam int FIX_N  = mtrr_pkg::FIXED_REGS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FIX  = 2'd1;
   localparam logic [1:0] ST_VAR  = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   logic [1:0]           state_ff, state_in;
   mtrr_pkg::op_type     cur_ff, cur_in;
   logic [11:0]          def_ff, def_in;
   logic [FIX_N-1:0]     fix_vld_ff, fix_vld_in;
   logic [VAR_PAIRS-1:0] base_vld_ff, base_vld_in;
   logic [VAR_PAIRS-1:0] mask_vld_ff, mask_vld_in;
   logic [4:0]           walk_ff, walk_in;
   logic [7:0]           cur_ty_ff, cur_ty_in;
   logic                 have_ff, have_in;
   logic                 fix_rv_ff, fix_rv_in;
   logic                 base_rv_ff, base_rv_in;
   logic                 mask_rv_ff, mask_rv_in;
   mtrr_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [3:0]           fix_raddr;
   logic [4:0]           pair_raw;
   logic [PAIR_W-1:0]    pair_raddr;
   logic [PAIR_W-1:0]    pair_waddr;
   logic [PAIR_N-1:0]    base_vld_pad, mask_vld_pad;
   logic [63:0]          fix_q, base_q, mask_q;
   logic [63:0]          fdata, bdata, mdata, slot;
   logic                 fix_we, base_we, mask_we;
   logic [63:0]          am;
   logic [5:0]           eff_bits;
   logic [63:0]          chk_b, chk_m;
   logic                 var_ok;
   logic [63:0]          walk_mm;
   logic                 walk_hit;
   logic [7:0]           walk_t;
   logic [7:0]           nxt_ty;
   logic                 walk_conflict;
   logic                 walk_last;
   logic                 start;

   assign fix_raddr  = head.fix_sel;
   assign pair_raw   = (state_ff == ST_WALK) ? walk_ff + 5'd1 :
                       (head.kind == mtrr_pkg::KIND_LOOKUP) ? 5'd0 : {1'b0, head.pair};
   assign pair_raddr = pair_raw[PAIR_W-1:0];
   assign pair_waddr = cur_ff.pair[PAIR_W-1:0];

   assign base_vld_pad = PAIR_N'(base_vld_ff);
   assign mask_vld_pad = PAIR_N'(mask_vld_ff);
   assign fix_rv_in    = fix_vld_ff[fix_raddr];
   assign base_rv_in   = base_vld_pad[pair_raddr];
   assign mask_rv_in   = mask_vld_pad[pair_raddr];

   mtrr_ram #(.WIDTH(64), .DEPTH(FIX_N)) u_fix_ram (
      .clock (clock),
      .we    (fix_we),
      .waddr (cur_ff.fix_sel),
      .wdata (cur_ff.value),
      .raddr (fix_raddr),
      .rdata (fix_q)
   );

   mtrr_ram #(.WIDTH(64), .DEPTH(VAR_PAIRS)) u_base_ram (
      .clock (clock),
      .we    (base_we),
      .waddr (pair_waddr),
      .wdata (cur_ff.value),
      .raddr (pair_raddr),
      .rdata (base_q)
   );

   mtrr_ram #(.WIDTH(64), .DEPTH(VAR_PAIRS)) u_mask_ram (
      .clock (clock),
      .we    (mask_we),
      .waddr (pair_waddr),
      .wdata (cur_ff.value),
      .raddr (pair_raddr),
      .rdata (mask_q)
   );

   // never-written entries read as zero
   assign fdata = fix_rv_ff ? fix_q : 64'd0;
   assign bdata = base_rv_ff ? base_q : 64'd0;
   assign mdata = mask_rv_ff ? mask_q : 64'd0;
   assign slot  = (cur_ff.target == mtrr_pkg::TGT_MASK) ? mdata : bdata;

   // allowed address bits [eff_bits-1:12]
   assign eff_bits = phys_bits[5] ? phys_bits : 6'd32;
   always_comb begin
      for (int j = 0; j < 64; j++) begin
         am[j] = (j >= 12) && (6'(j) < eff_bits);
      end
   end

   always_comb begin
      chk_b  = (cur_ff.target == mtrr_pkg::TGT_MASK) ? bdata : cur_ff.value;
      chk_m  = (cur_ff.target == mtrr_pkg::TGT_MASK) ? cur_ff.value : mdata;
      var_ok = ((chk_b & ~(am | mtrr_pkg::BASE_TYPE)) == 64'd0) &&
               ((chk_m & ~(am | mtrr_pkg::MASK_VALID)) == 64'd0) &&
               !(chk_m[11] && !mtrr_pkg::type_ok(chk_b[7:0]));
   end

   // one variable pair per cycle
   always_comb begin
      walk_mm       = {mdata[63:12], 12'd0};
      walk_t        = bdata[7:0];
      walk_hit      = mdata[11] && (({1'b0, cur_ff.address} & walk_mm) == (bdata & walk_mm));
      nxt_ty        = cur_ty_ff;
      walk_conflict = 1'b0;
      if (walk_hit) begin
         if (!have_ff || cur_ty_ff == walk_t) begin
            nxt_ty = walk_t;
         end else if (cur_ty_ff == mtrr_pkg::TYPE_UC || walk_t == mtrr_pkg::TYPE_UC) begin
            nxt_ty = mtrr_pkg::TYPE_UC;
         end else if ((cur_ty_ff == mtrr_pkg::TYPE_WB && walk_t == mtrr_pkg::TYPE_WT) ||
                      (cur_ty_ff == mtrr_pkg::TYPE_WT && walk_t == mtrr_pkg::TYPE_WB)) begin
            nxt_ty = mtrr_pkg::TYPE_WT;
         end else begin
            walk_conflict = 1'b1;
         end
      end
      walk_last = ((walk_ff + 5'd1) == pairs_used);
   end

   assign start = (state_ff == ST_IDLE) && !q_empty && !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      def_in       = def_ff;
      fix_vld_in   = fix_vld_ff;
      base_vld_in  = base_vld_ff;
      mask_vld_in  = mask_vld_ff;
      walk_in      = walk_ff;
      cur_ty_in    = cur_ty_ff;
      have_in      = have_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      fix_we       = 1'b0;
      base_we      = 1'b0;
      mask_we      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               q_pop        = 1'b1;
               cur_in       = head;
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               case (head.kind)
                  mtrr_pkg::KIND_LOOKUP: begin
                     if (!def_ff[11]) begin
                        rsp_in.mem_type = mtrr_pkg::TYPE_UC[2:0];
                     end else if (head.addr_low && def_ff[10]) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_FIX;
                     end else if (pairs_used == 5'd0) begin
                        rsp_in.mem_type = def_ff[2:0];
                     end else begin
                        rsp_valid_in = 1'b0;
                        walk_in      = 5'd0;
                        have_in      = 1'b0;
                        cur_ty_in    = mtrr_pkg::TYPE_UC;
                        state_in     = ST_WALK;
                     end
                  end
                  mtrr_pkg::KIND_READ,
                  mtrr_pkg::KIND_WRITE: begin
                     if (head.target == mtrr_pkg::TGT_DEF) begin
                        if (head.kind == mtrr_pkg::KIND_READ) begin
                           rsp_in.read_data = {52'd0, def_ff};
                        end else if (head.value != {52'd0, def_ff}) begin
                           if (!head.val_ok) begin
                              rsp_in.status = mtrr_pkg::STAT_REJECT;
                           end else begin
                              def_in     = head.value[11:0];
                              rsp_in.upd = 1'b1;
                           end
                        end
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = (head.target == mtrr_pkg::TGT_FIX) ? ST_FIX : ST_VAR;
                     end
                  end
                  mtrr_pkg::KIND_UNKNOWN: begin
                     rsp_in.status = mtrr_pkg::STAT_UNKNOWN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIX: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (cur_ff.kind)
               mtrr_pkg::KIND_LOOKUP: begin
                  rsp_in.mem_type = fdata[{cur_ff.fix_byte, 3'b000} +: 3];
               end
               mtrr_pkg::KIND_READ: begin
                  rsp_in.read_data = fdata;
               end
               default: begin
                  if (!cur_ff.val_ok) begin
                     rsp_in.status = mtrr_pkg::STAT_REJECT;
                  end else if (cur_ff.value != fdata) begin
                     fix_we                     = 1'b1;
                     fix_vld_in[cur_ff.fix_sel] = 1'b1;
                     rsp_in.upd                 = def_ff[11] & def_ff[10];
                  end
               end
            endcase
         end
         ST_VAR: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (cur_ff.kind == mtrr_pkg::KIND_READ) begin
               rsp_in.read_data = slot;
            end else if (cur_ff.value != slot) begin
               if (!var_ok) begin
                  rsp_in.status = mtrr_pkg::STAT_REJECT;
               end else begin
                  rsp_in.upd = def_ff[11];
                  if (cur_ff.target == mtrr_pkg::TGT_MASK) begin
                     mask_we                 = 1'b1;
                     mask_vld_in[pair_waddr] = 1'b1;
                  end else begin
                     base_we                 = 1'b1;
                     base_vld_in[pair_waddr] = 1'b1;
                  end
               end
            end
         end
         ST_WALK: begin
            cur_ty_in = nxt_ty;
            have_in   = have_ff | walk_hit;
            walk_in   = walk_ff + 5'd1;
            if (walk_conflict || walk_last) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (walk_conflict) begin
                  rsp_in.status = mtrr_pkg::STAT_CONFLICT;
               end else begin
                  rsp_in.mem_type = (have_ff | walk_hit) ? nxt_ty[2:0] : def_ff[2:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         def_ff       <= 12'd0;
         fix_vld_ff   <= '0;
         base_vld_ff  <= '0;
         mask_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         def_ff       <= def_in;
         fix_vld_ff   <= fix_vld_in;
         base_vld_ff  <= base_vld_in;
         mask_vld_ff  <= mask_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      walk_ff    <= walk_in;
      cur_ty_ff  <= cur_ty_in;
      have_ff    <= have_in;
      fix_rv_ff  <= fix_rv_in;
      base_rv_ff <= base_rv_in;
      mask_rv_ff <= mask_rv_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/mtrr_memory_type_resolver.sv]
// ----------------------------------------------------------------------------
// mtrr_memory_type_resolver
// MTRR register set with validated register access and memory-type lookup.
// ----------------------------------------------------------------------------
// Request words are decoded in the front end and queued (two words deep) for
// the back-end sequencer, which handles one word at a time. Unknown-register
// words, no-ops, disabled lookups and default-type accesses are answered
// straight from the idle state; fixed-range and variable register accesses
// and fixed-range lookups go through one registered RAM read each; a lookup
// in the variable ranges walks the N pairs in use (up to VAR_PAIRS) with one
// base/mask RAM read per pair, ending early on a type conflict. A finished
// response word waits in the output register while the front end keeps
// accepting; the sequencer starts the next word only once that word has
// left. Registers read as zero after reset through per-entry valid bits, so
// no clearing pass is needed. The csr port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_memory_type_resolver #(
   parameter int VAR_PAIRS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mtrr_req_if.sink    req_ch,
   mtrr_rsp_if.source  rsp_ch,
   mtrr_csr_if.sink    csr_ch
);

   logic [5:0]        phys_bits_ff, phys_bits_in;
   logic [3:0]        pairs_ff, pairs_in;
   logic [4:0]        pairs_used;
   logic              q_push, q_full, q_pop, q_empty;
   mtrr_pkg::op_type  q_data, q_head;
   mtrr_pkg::rsp_type rsp;
   logic              rsp_valid;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      phys_bits_in = phys_bits_ff;
      pairs_in     = pairs_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            mtrr_pkg::CSR_PHYS_BITS: phys_bits_in = csr_ch.data[5:0];
            mtrr_pkg::CSR_PAIRS:     pairs_in     = csr_ch.data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_bits_ff <= 6'd36;
         pairs_ff     <= 4'd8;
      end else begin
         phys_bits_ff <= phys_bits_in;
         pairs_ff     <= pairs_in;
      end
   end

   assign pairs_used = ({1'b0, pairs_ff} > 5'(VAR_PAIRS)) ? 5'(VAR_PAIRS) : {1'b0, pairs_ff};

   mtrr_front u_front (
      .req        (req_ch),
      .pairs_used (pairs_used),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   mtrr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   mtrr_back #(.VAR_PAIRS(VAR_PAIRS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (q_head),
      .q_pop      (q_pop),
      .phys_bits  (phys_bits_ff),
      .pairs_used (pairs_used),
      .rsp        (rsp),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ch.ready)
   );

   assign rsp_ch.valid               = rsp_valid;
   assign rsp_ch.mem_type            = rsp.mem_type;
   assign rsp_ch.read_data           = rsp.read_data;
   assign rsp_ch.status              = rsp.status;
   assign rsp_ch.table_update_needed = rsp.upd;

`ifndef SYNTHESIS
   a_conflict_uc: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == mtrr_pkg::STAT_CONFLICT) |->
      (rsp_ch.mem_type == 3'd0 && rsp_ch.read_data == 64'd0))
      else $error("conflict response carries a type or data");

   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != mtrr_pkg::STAT_OK) |->
      (!rsp_ch.table_update_needed && rsp_ch.read_data == 64'd0))
      else $error("failed word flags an update or returns data");

   a_update_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.table_update_needed) |->
      (rsp_ch.mem_type == 3'd0 && rsp_ch.read_data == 64'd0))
      else $error("update word mixed with lookup or read result");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!q_empty && !rsp_valid))
      else $error("sequencer started without a queued word or free output");
`endif

endmodule

`default_nettype wire
